>>> hdl/cip_pkg.sv
// package with payload types, register indexes and fixed-point helpers
package cip_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CfgW  = 31;

  typedef enum logic [0:0] {
    REG_TIME_STEP   = 1'b0,
    REG_INV_SPACING = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [DataW-1:0] val_up;
    logic signed [DataW-1:0] val_here;
    logic signed [DataW-1:0] slope_up;
    logic signed [DataW-1:0] slope_here;
    logic signed [DataW-1:0] cross_up;
    logic signed [DataW-1:0] cross_here;
    logic signed [DataW-1:0] mixed_up;
    logic signed [DataW-1:0] mixed_here;
    logic signed [DataW-1:0] velocity;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] val_new;
    logic signed [DataW-1:0] slope_new;
    logic signed [DataW-1:0] cross_new;
    logic signed [DataW-1:0] mixed_new;
    logic                    overflow;
  } out_item_t;

  // one value/slope pair, upwind and local samples
  typedef struct packed {
    logic signed [DataW-1:0] v_up;
    logic signed [DataW-1:0] v_here;
    logic signed [DataW-1:0] s_up;
    logic signed [DataW-1:0] s_here;
  } pair_t;

  // clamp a wide signed value to 32 bits, flag on change
  function automatic logic [DataW:0] sat32(input logic signed [71:0] v);
    logic signed [71:0] mx;
    logic signed [71:0] mn;
    mx = 72'sh7FFFFFFF;
    mn = -72'sh80000000;
    if (v > mx) return {1'b1, mx[DataW-1:0]};
    if (v < mn) return {1'b1, mn[DataW-1:0]};
    return {1'b0, v[DataW-1:0]};
  endfunction

endpackage

>>> hdl/cip_mul.sv
// registered 32x32 signed multiply with rounding and clamp
module cip_mul #(
  parameter int unsigned FracBits = 24
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [31:0]  a_i,
  input  logic signed [31:0]  b_i,
  output logic signed [31:0]  p_o,
  output logic                ovf_o
);
  logic signed [63:0] prod_q;
  logic signed [71:0] rnd;
  logic [32:0]        s;

  // product register
  always_ff @(posedge clk_i) begin
    if (en_i) prod_q <= a_i * b_i;
  end

  // round half up then clamp
  always_comb begin
    rnd = ($signed({{8{prod_q[63]}}, prod_q}) + (72'sd1 <<< (FracBits-1))) >>> FracBits;
    s   = cip_pkg::sat32(rnd);
  end

  assign p_o   = s[31:0];
  assign ovf_o = s[32];
endmodule

>>> hdl/cip_pair.sv
// pipelined cip evaluation of one value/slope pair
module cip_pair #(
  parameter int unsigned FracBits = 24
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  cip_pkg::pair_t        pair_i,
  input  logic signed [31:0]    x_i,
  input  logic signed [31:0]    g_i,
  input  logic signed [31:0]    g2_i,
  input  logic signed [31:0]    g3_i,
  input  logic                  ovf_i,
  output logic signed [31:0]    val_o,
  output logic signed [31:0]    slope_o,
  output logic                  ovf_o
);
  // stage registers carry pair, x and overflow down the pipe
  cip_pkg::pair_t     p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [31:0] x1_q, x2_q, x3_q, x4_q, x5_q;
  logic signed [31:0] g1_q, g21_q, g31_q, dv1_q, sum1_q, sum21_q;
  logic               o1_q, o2_q, o3_q, o4_q, o5_q;
  logic signed [31:0] a3_q, b3_q, b4_q, t5a_q, t5b_q;
  logic [32:0] s_dv, s_sum, s_sum2, s_a, s_b, s_ta, s_tb, s_v1, s_v2, s_sl;

  // stage 1: difference and clamped sums
  always_comb begin
    s_dv   = cip_pkg::sat32(72'(pair_i.v_here) - 72'(pair_i.v_up));
    s_sum  = cip_pkg::sat32(72'(pair_i.s_here) + 72'(pair_i.s_up));
    s_sum2 = cip_pkg::sat32(72'(pair_i.s_here) * 72'sd2 + 72'(pair_i.s_up));
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q <= pair_i; x1_q <= x_i; g1_q <= g_i; g21_q <= g2_i; g31_q <= g3_i;
      dv1_q <= s_dv[31:0]; sum1_q <= s_sum[31:0]; sum21_q <= s_sum2[31:0];
      o1_q <= ovf_i | s_dv[32] | s_sum[32] | s_sum2[32];
    end
  end

  // stage 2: four coefficient products
  logic signed [31:0] m_a0, m_a1, m_b0, m_b1;
  logic               f_a0, f_a1, f_b0, f_b1;
  cip_mul #(.FracBits(FracBits)) u_ma0 (.clk_i, .en_i, .a_i(sum1_q), .b_i(g21_q),
    .p_o(m_a0), .ovf_o(f_a0));
  cip_mul #(.FracBits(FracBits)) u_ma1 (.clk_i, .en_i, .a_i(dv1_q), .b_i(g31_q),
    .p_o(m_a1), .ovf_o(f_a1));
  cip_mul #(.FracBits(FracBits)) u_mb0 (.clk_i, .en_i, .a_i(sum21_q), .b_i(g1_q),
    .p_o(m_b0), .ovf_o(f_b0));
  cip_mul #(.FracBits(FracBits)) u_mb1 (.clk_i, .en_i, .a_i(dv1_q), .b_i(g21_q),
    .p_o(m_b1), .ovf_o(f_b1));
  always_ff @(posedge clk_i) begin
    if (en_i) begin p2_q <= p1_q; x2_q <= x1_q; o2_q <= o1_q; end
  end

  // stage 3: coefficients a and b
  always_comb begin
    s_a = cip_pkg::sat32(72'(m_a0) - 72'sd2 * 72'(m_a1));
    s_b = cip_pkg::sat32(72'(m_b0) - 72'sd3 * 72'(m_b1));
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p3_q <= p2_q; x3_q <= x2_q; a3_q <= s_a[31:0]; b3_q <= s_b[31:0];
      o3_q <= o2_q | f_a0 | f_a1 | f_b0 | f_b1 | s_a[32] | s_b[32];
    end
  end

  // stage 4: a*x
  logic signed [31:0] m_ax;
  logic               f_ax;
  cip_mul #(.FracBits(FracBits)) u_ax (.clk_i, .en_i, .a_i(a3_q), .b_i(x3_q),
    .p_o(m_ax), .ovf_o(f_ax));
  always_ff @(posedge clk_i) begin
    if (en_i) begin p4_q <= p3_q; x4_q <= x3_q; b4_q <= b3_q; o4_q <= o3_q; end
  end

  // stage 5: inner sums for value and slope
  always_comb begin
    s_ta = cip_pkg::sat32(72'(m_ax) + 72'(b4_q));
    s_tb = cip_pkg::sat32(72'sd3 * 72'(m_ax) + 72'sd2 * 72'(b4_q));
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p5_q <= p4_q; x5_q <= x4_q; t5a_q <= s_ta[31:0]; t5b_q <= s_tb[31:0];
      o5_q <= o4_q | f_ax | s_ta[32] | s_tb[32];
    end
  end

  // stage 6: multiply both by x
  logic signed [31:0] m_va, m_sl;
  logic               f_va, f_sl;
  logic signed [31:0] x6_q, v6_q, sh6_q, t7_q, v7_q, x7_q, sl7_q;
  logic               o6_q, o7_q;
  cip_mul #(.FracBits(FracBits)) u_va (.clk_i, .en_i, .a_i(t5a_q), .b_i(x5_q),
    .p_o(m_va), .ovf_o(f_va));
  cip_mul #(.FracBits(FracBits)) u_sl (.clk_i, .en_i, .a_i(t5b_q), .b_i(x5_q),
    .p_o(m_sl), .ovf_o(f_sl));
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x6_q <= x5_q; v6_q <= p5_q.v_here; sh6_q <= p5_q.s_here; o6_q <= o5_q;
    end
  end

  // stage 7: add slope term, final slope out
  always_comb begin
    s_v1 = cip_pkg::sat32(72'(m_va) + 72'(sh6_q));
    s_sl = cip_pkg::sat32(72'(m_sl) + 72'(sh6_q));
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t7_q <= s_v1[31:0]; v7_q <= v6_q; x7_q <= x6_q; sl7_q <= s_sl[31:0];
      o7_q <= o6_q | f_va | f_sl | s_v1[32] | s_sl[32];
    end
  end

  // stage 8: last multiply and value add
  logic signed [31:0] m_fin;
  logic               f_fin;
  logic signed [31:0] v8_q, sl8_q;
  logic               o8_q;
  cip_mul #(.FracBits(FracBits)) u_fin (.clk_i, .en_i, .a_i(t7_q), .b_i(x7_q),
    .p_o(m_fin), .ovf_o(f_fin));
  always_ff @(posedge clk_i) begin
    if (en_i) begin v8_q <= v7_q; sl8_q <= sl7_q; o8_q <= o7_q; end
  end
  assign s_v2    = cip_pkg::sat32(72'(m_fin) + 72'(v8_q));
  assign val_o   = s_v2[31:0];
  assign slope_o = sl8_q;
  assign ovf_o   = o8_q | f_fin | s_v2[32];
endmodule

>>> hdl/cip_front.sv
// front: config registers, displacement and spacing powers, input queue
module cip_front #(
  parameter int unsigned FracBits = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [0:0]           cfg_index_i,
  input  logic                 cfg_index_hi_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cip_pkg::in_item_t    in_data_i,
  input  logic                 deq_i,
  output logic                 q_valid_o,
  output cip_pkg::in_item_t    q_item_o,
  output logic signed [31:0]   x_o,
  output logic signed [31:0]   g_o,
  output logic signed [31:0]   g2_o,
  output logic signed [31:0]   g3_o,
  output logic                 ovf_o
);
  logic [cip_pkg::CfgW-1:0] ts_q, gs_q;
  logic signed [31:0] g2_q, g3_q;
  logic               og2_q, og3_q;
  logic [32:0] s;
  logic [1:0]  settle_q;

  assign cfg_ready_o = 1'b1;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q <= '0;
      gs_q <= cip_pkg::CfgW'(1) << FracBits;
    end else if (cfg_valid_i && !cfg_index_hi_i) begin
      unique case (cip_pkg::reg_idx_e'(cfg_index_i))
        cip_pkg::REG_TIME_STEP:   ts_q <= cfg_data_i[cip_pkg::CfgW-1:0];
        cip_pkg::REG_INV_SPACING: gs_q <= cfg_data_i[cip_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  // spacing powers recomputed each cycle, two register stages after a write
  logic signed [63:0] pg2, pg3;
  logic signed [71:0] r2, r3;
  logic [32:0]        s2, s3;
  always_comb begin
    pg2 = $signed({33'd0, gs_q}) * $signed({33'd0, gs_q});
    r2  = ($signed({{8{pg2[63]}}, pg2}) + (72'sd1 <<< (FracBits-1))) >>> FracBits;
    s2  = cip_pkg::sat32(r2);
    pg3 = g2_q * $signed({1'b0, gs_q});
    r3  = ($signed({{8{pg3[63]}}, pg3}) + (72'sd1 <<< (FracBits-1))) >>> FracBits;
    s3  = cip_pkg::sat32(r3);
  end
  always_ff @(posedge clk_i) begin
    g2_q <= s2[31:0]; og2_q <= s2[32];
    g3_q <= s3[31:0]; og3_q <= s3[32];
  end

  // hold the queue output while the spacing powers settle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= 2'd2;
    end else if (cfg_valid_i) begin
      settle_q <= 2'd2;
    end else if (settle_q != 2'd0) begin
      settle_q <= settle_q - 2'd1;
    end
  end

  // two-entry queue
  cip_pkg::in_item_t  mem_q [2];
  logic [1:0]         cnt_q;
  logic               wp_q, rp_q;
  logic signed [63:0] pv;
  logic signed [71:0] rv;
  logic               push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0) && (settle_q == 2'd0);
  assign q_item_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; wp_q <= 1'b0; rp_q <= 1'b0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (deq_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, deq_i};
    end
  end

  // displacement x = -(velocity * time_step), rounded and clamped
  always_comb begin
    pv = -(q_item_o.velocity * $signed({1'b0, ts_q}));
    rv = ($signed({{8{pv[63]}}, pv}) + (72'sd1 <<< (FracBits-1))) >>> FracBits;
    s  = cip_pkg::sat32(rv);
  end
  assign x_o   = s[31:0];
  assign g_o   = $signed({1'b0, gs_q});
  assign g2_o  = g2_q;
  assign g3_o  = g3_q;
  assign ovf_o = s[32] | og2_q | og3_q;
endmodule

>>> hdl/cip_cubic_advection_kernel.sv
// top level: cip cubic advection kernel, one grid cell per transaction
// datapath: input queue, 8 pipe stages in cip_pair, then the output register
// throughput: one cell per cycle unless stalled, set by fully pipelined multipliers
// the pipeline holds under output stall; a two-entry input queue absorbs stall
// reset: asynchronous active low, clears queue and valids; time_step 0, spacing 1.0
// queue output held after reset or a register write until both spacing powers settle
module cip_cubic_advection_kernel #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cip_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cip_pkg::out_item_t  out_data_o
);
  localparam int unsigned Depth = 9;

  logic               q_valid, deq, en;
  cip_pkg::in_item_t  qi;
  logic signed [31:0] x, g, g2, g3, v0, s0, v1, s1;
  logic               fovf, o0, o1;
  logic [Depth-1:0]   vld_q;

  cip_front #(.FracBits(FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i(cfg_index_i[0:0]), .cfg_index_hi_i(|cfg_index_i[31:1]),
    .cfg_data_i, .in_valid_i, .in_ready_o, .in_data_i,
    .deq_i(deq), .q_valid_o(q_valid), .q_item_o(qi),
    .x_o(x), .g_o(g), .g2_o(g2), .g3_o(g3), .ovf_o(fovf));

  // pipe advances unless the output is full and stalled
  assign en  = !(vld_q[Depth-1] && !out_ready_i);
  assign deq = en && q_valid;

  cip_pair #(.FracBits(FRAC_BITS)) u_p0 (.clk_i, .en_i(en),
    .pair_i('{qi.val_up, qi.val_here, qi.slope_up, qi.slope_here}),
    .x_i(x), .g_i(g), .g2_i(g2), .g3_i(g3), .ovf_i(fovf),
    .val_o(v0), .slope_o(s0), .ovf_o(o0));
  cip_pair #(.FracBits(FRAC_BITS)) u_p1 (.clk_i, .en_i(en),
    .pair_i('{qi.cross_up, qi.cross_here, qi.mixed_up, qi.mixed_here}),
    .x_i(x), .g_i(g), .g2_i(g2), .g3_i(g3), .ovf_i(1'b0),
    .val_o(v1), .slope_o(s1), .ovf_o(o1));

  // output register
  always_ff @(posedge clk_i) begin
    if (en) out_data_o <= '{v0, s0, v1, s1, o0 | o1};
  end

  // valid shift line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Depth-2:0], deq};
  end
  assign out_valid_o = vld_q[Depth-1];

  // a stalled result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed under stall");
  // nothing dequeued while the pipe is frozen
  a_deq: assert property (@(posedge clk_i) disable iff (!rst_ni) deq |-> en)
    else $error("dequeue while stalled");
  // pipe only freezes behind a waiting result
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> en)
    else $error("pipe stalled without output");
endmodule

>>> tb/testbench.sv
// testbench for the cip cubic advection kernel: directed and random cells against a predictor
module testbench;

  localparam int unsigned FracBits  = 24;
  localparam int unsigned BogusIdx  = 7;
  localparam int unsigned DrainWait = 16;
  localparam int unsigned WdogLimit = 4000;
  localparam longint      MaxS32    = 64'sh7FFFFFFF;
  localparam longint      MinS32    = -64'sh80000000;
  localparam logic [31:0] OneQ      = 32'h0100_0000;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [31:0] cfg_index_i;
  logic [31:0] cfg_data_i;
  logic      in_valid_i;
  logic      in_ready_o;
  cip_pkg::in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  cip_pkg::out_item_t out_data_o;

  cip_cubic_advection_kernel DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // model copy of the registers
  logic [30:0] step_reg;
  logic [30:0] spacing_reg;
  bit          sat_seen;
  cip_pkg::out_item_t pending_cells[$];
  int unsigned fail_cnt;
  bit          no_idle;
  int unsigned wdog_cnt;

  // clamp to signed 32 bits, noting any change
  function automatic longint clamp32(input longint v);
    if (v > MaxS32) begin
      sat_seen = 1'b1;
      return MaxS32;
    end
    if (v < MinS32) begin
      sat_seen = 1'b1;
      return MinS32;
    end
    return v;
  endfunction

  // round half up to the fraction width
  function automatic longint round_q(input longint p);
    return (p + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return clamp32(round_q(a * b));
  endfunction

  // hermite cubic of one pair evaluated at x
  function automatic void advect(input longint vu, input longint vh, input longint su,
                                 input longint sh, input longint g, input longint g2,
                                 input longint g3, input longint x,
                                 output longint val, output longint slp);
    longint dv, a, b, ax, t;
    dv  = clamp32(vh - vu);
    a   = clamp32(qmul(clamp32(sh + su), g2) - 2 * qmul(dv, g3));
    b   = clamp32(qmul(clamp32(2 * sh + su), g) - 3 * qmul(dv, g2));
    ax  = qmul(a, x);
    t   = clamp32(ax + b);
    t   = clamp32(qmul(t, x) + sh);
    val = clamp32(qmul(t, x) + vh);
    t   = clamp32(3 * ax + 2 * b);
    slp = clamp32(qmul(t, x) + sh);
  endfunction

  function automatic cip_pkg::out_item_t advect_cell(input cip_pkg::in_item_t c);
    cip_pkg::out_item_t r;
    longint g, g2, g3, x, v0, v1, v2, v3;
    sat_seen = 1'b0;
    g  = longint'(spacing_reg);
    x  = clamp32(round_q(-(longint'(c.velocity) * longint'(step_reg))));
    g2 = qmul(g, g);
    g3 = qmul(g2, g);
    advect(c.val_up, c.val_here, c.slope_up, c.slope_here, g, g2, g3, x, v0, v1);
    advect(c.cross_up, c.cross_here, c.mixed_up, c.mixed_here, g, g2, g3, x, v2, v3);
    r.val_new   = v0[31:0];
    r.slope_new = v1[31:0];
    r.cross_new = v2[31:0];
    r.mixed_new = v3[31:0];
    r.overflow  = sat_seen;
    return r;
  endfunction

  // gap length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // sink side stalls
  int unsigned stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (no_idle || $urandom_range(3) != 0) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= 1'b0;
      stall_left  <= pick_gap();
    end
  end

  // result check: a transaction seen at the falling edge completes at the next rising edge
  always @(negedge clk_i) begin
    cip_pkg::out_item_t exp_cell;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_cells.size() == 0) begin
        $error("result with no expectation waiting: %h", out_data_o);
        fail_cnt++;
      end else begin
        exp_cell = pending_cells.pop_front();
        if (out_data_o.val_new !== exp_cell.val_new) begin
          $error("val_new exp %h got %h", exp_cell.val_new, out_data_o.val_new);
          fail_cnt++;
        end
        if (out_data_o.slope_new !== exp_cell.slope_new) begin
          $error("slope_new exp %h got %h", exp_cell.slope_new, out_data_o.slope_new);
          fail_cnt++;
        end
        if (out_data_o.cross_new !== exp_cell.cross_new) begin
          $error("cross_new exp %h got %h", exp_cell.cross_new, out_data_o.cross_new);
          fail_cnt++;
        end
        if (out_data_o.mixed_new !== exp_cell.mixed_new) begin
          $error("mixed_new exp %h got %h", exp_cell.mixed_new, out_data_o.mixed_new);
          fail_cnt++;
        end
        if (out_data_o.overflow !== exp_cell.overflow) begin
          $error("overflow exp %b got %b", exp_cell.overflow, out_data_o.overflow);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(negedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      wdog_cnt = 0;
    end else begin
      wdog_cnt++;
    end
    if (wdog_cnt >= WdogLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // send one cell and log its expected result; valid drops only for a gap
  task automatic send_cell(input cip_pkg::in_item_t c);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    pending_cells.push_back(advect_cell(c));
  endtask

  // stop sending, wait until every expected result is back, then let the pipe empty
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // register write while idle; waits afterwards so the spacing powers settle
  task automatic write_reg(input logic [31:0] idx, input logic [31:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == cip_pkg::REG_TIME_STEP) step_reg = data[30:0];
    else if (idx == cip_pkg::REG_INV_SPACING) spacing_reg = data[30:0];
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // field value: full range, moderate, or an extreme
  function automatic logic [31:0] rand_field(input int unsigned span_log);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return $urandom();
    if (r < 92) return $urandom_range((1 << span_log) - 1) - (1 << (span_log - 1));
    case ($urandom_range(3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic cip_pkg::in_item_t rand_cell();
    cip_pkg::in_item_t c;
    c.val_up     = rand_field(27);
    c.val_here   = rand_field(27);
    c.slope_up   = rand_field(26);
    c.slope_here = rand_field(26);
    c.cross_up   = rand_field(27);
    c.cross_here = rand_field(27);
    c.mixed_up   = rand_field(26);
    c.mixed_here = rand_field(26);
    c.velocity   = rand_field(25);
    return c;
  endfunction

  function automatic cip_pkg::in_item_t flat_cell(input logic [31:0] v,
                                                  input logic [31:0] vel);
    cip_pkg::in_item_t c;
    c = {9{v}};
    c.velocity = vel;
    return c;
  endfunction

  // defaults after reset: zero step, so the result is the local sample
  task automatic test_reset_defaults();
    send_cell(flat_cell(32'h0123_4567, 32'h7FFF_FFFF));
    send_cell(rand_cell());
  endtask

  // field extremes under a small step and unit spacing
  task automatic test_extremes();
    cip_pkg::in_item_t c;
    write_reg(cip_pkg::REG_TIME_STEP, 32'h0004_0000);
    send_cell(flat_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_cell(flat_cell(32'h8000_0000, 32'h8000_0000));
    send_cell(flat_cell(32'h0, 32'h0));
    send_cell(flat_cell(32'hAAAA_AAAA, 32'h5555_5555));
    send_cell(flat_cell(32'h5555_5555, 32'hAAAA_AAAA));
    c = flat_cell(32'h0, OneQ);
    c.val_up = 32'h7FFF_FFFF;
    c.val_here = 32'h8000_0000;
    c.cross_up = 32'h8000_0000;
    c.cross_here = 32'h7FFF_FFFF;
    send_cell(c);
    c = flat_cell(32'h0100_0000, 32'hFF00_0000);
    c.slope_here = 32'h7FFF_FFFF;
    c.mixed_up = 32'h8000_0000;
    send_cell(c);
    // saturating intermediates with the largest registers
    write_reg(cip_pkg::REG_TIME_STEP, 32'h7FFF_FFFF);
    write_reg(cip_pkg::REG_INV_SPACING, 32'h7FFF_FFFF);
    send_cell(flat_cell(32'h0000_0001, 32'h0000_0001));
    send_cell(flat_cell(32'h0100_0000, 32'h8000_0000));
    send_cell(rand_cell());
  endtask

  // zero spacing, ignored upper bit and unknown register index
  task automatic test_register_quirks();
    write_reg(cip_pkg::REG_INV_SPACING, 32'h0);
    write_reg(cip_pkg::REG_TIME_STEP, 32'h8100_0000);
    send_cell(flat_cell(32'h0040_0000, 32'h0080_0000));
    send_cell(flat_cell(32'h7FFF_FFFF, 32'h8000_0000));
    write_reg(BogusIdx, 32'h1234_5678);
    write_reg(cip_pkg::REG_INV_SPACING, 32'h8200_0000);
    send_cell(flat_cell(32'hFFC0_0000, 32'h0030_0000));
    send_cell(rand_cell());
  endtask

  // random cells under a spread of register settings
  task automatic test_random_cells();
    logic [31:0] steps[4];
    logic [31:0] spacings[4];
    steps    = '{32'h0002_8F5C, 32'h0000_0000, 32'h0100_0000, 32'h7FFF_FFFF};
    spacings = '{32'h0100_0000, 32'h0400_0000, 32'h0000_0000, 32'h7FFF_FFFF};
    for (int p = 0; p < 4; p++) begin
      write_reg(cip_pkg::REG_TIME_STEP, steps[p]);
      write_reg(cip_pkg::REG_INV_SPACING, spacings[p]);
      for (int n = 0; n < 210; n++) begin
        if (n % 50 == 0) no_idle = ($urandom_range(2) == 0);
        send_cell(rand_cell());
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    step_reg    = '0;
    spacing_reg = OneQ[30:0];
    fail_cnt    = 0;
    no_idle     = 1'b0;
    wdog_cnt    = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_extremes();
    test_register_quirks();
    test_random_cells();
    drain();
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/cip_pkg.sv
hdl/cip_mul.sv
hdl/cip_pair.sv
hdl/cip_front.sv
hdl/cip_cubic_advection_kernel.sv
tb/testbench.sv
